[hw/rtl/assert_macros.svh]
// ---------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros for the field splitter checkers. Expect clk and arst_n
// in the scope of use.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define DFS_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("field splitter check failed");

// next-cycle implication
`define DFS_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("field splitter check failed");

`endif

[hw/rtl/dfs_pkg.sv]
// ---------------------------------------------------------------------------
// dfs_pkg
// Shared constants and types of the delimited field splitter.
// ---------------------------------------------------------------------------
package dfs_pkg;

	localparam int MAXF    = 64;
	localparam int MAXLEN  = 256;
	localparam int FIELD_W = $clog2(MAXF);
	localparam int LEN_W   = $clog2(MAXLEN);

	localparam int IDX_W   = 6;
	localparam int BYTE_W  = 8;

	localparam logic [BYTE_W-1:0] QUOTE_BYTE  = 8'h22;
	localparam logic [BYTE_W-1:0] DELIM_RESET = 8'd44;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);

	// result slots of one byte, emitted lowest first
	localparam int SLOT_OPEN  = 0;
	localparam int SLOT_DATA  = 1;
	localparam int SLOT_CLOSE = 2;
	localparam int SLOT_MARK  = 3;
	localparam int NSLOT      = 4;

	typedef struct packed {
		logic [IDX_W-1:0]  field_index;
		logic [BYTE_W-1:0] data;
		logic              err;
		logic              line_end;
		logic              close_quote;
		logic [NSLOT-1:0]  slots;
	} desc_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} push_t;

	typedef struct packed {
		logic  valid;
		desc_t desc;
	} head_t;

endpackage

[hw/rtl/delimited_field_splitter_unit.sv]
// ---------------------------------------------------------------------------
// delimited_field_splitter_unit
// Splits a byte stream line into quoted fields at a programmable delimiter.
// ---------------------------------------------------------------------------
//   port group  dir  content
//   s_*         in   one line byte per transaction, tlast on the final byte
//   m_*         out  one result per transaction, tlast on the last of a byte
//   cfg_*       in   delimiter write, 8 bits
//
// One byte per cycle while each byte yields one result and m_tready stays high;
// a byte with several results holds the output for each of them in turn,
// absorbed by a 4-entry descriptor queue. The output register port sets the rate.
// An input byte passes the descriptor queue and then the output register.
// arst_n clears line state, queue and output valid; delimiter resets to ','.
// s_tready drops only while the descriptor queue is full.
// ---------------------------------------------------------------------------
module delimited_field_splitter_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // data_byte
	input  logic        s_tlast,   // line_last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // field_index[5:0], value_byte[13:6], zero[15:14]
	output logic [3:0]  m_tuser,   // byte_valid, field_end, line_end, overflow_error
	output logic        m_tlast,   // last_of_run
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [7:0]  cfg_data   // delimiter
);
	import dfs_pkg::*;

	logic [BYTE_W-1:0] delim_q;
	logic              q_full, pop, accept;
	push_t             push;
	head_t             head;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			delim_q <= DELIM_RESET;
		end else if (cfg_valid && cfg_ready) begin
			delim_q <= cfg_data;
		end
	end

	dfs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.data_byte (s_tdata),
		.line_last (s_tlast),
		.delimiter (delim_q),
		.push      (push)
	);

	dfs_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.pop    (pop),
		.full   (q_full),
		.head   (head)
	);

	dfs_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.head     (head),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

[hw/rtl/dfs_front.sv]
// ---------------------------------------------------------------------------
// dfs_front
// Classifies each input byte against the line state and issues one
// descriptor of the results it causes, if it causes any.
// ---------------------------------------------------------------------------
module dfs_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       accept,
	input  logic [dfs_pkg::BYTE_W-1:0] data_byte,
	input  logic                       line_last,
	input  logic [dfs_pkg::BYTE_W-1:0] delimiter,
	output dfs_pkg::push_t             push
);
	import dfs_pkg::*;

	logic               in_field_q, in_quote_q, err_q;
	logic [FIELD_W-1:0] cf_q;
	logic [LEN_W-1:0]   kl_q;
	logic [BYTE_W-1:0]  lkb_q;

	logic               in_field_n, in_quote_n, err_n;
	logic [FIELD_W-1:0] cf_n;
	logic [LEN_W-1:0]   kl_n, kl_base;
	logic [BYTE_W-1:0]  lkb_n;
	logic               do_app, close_q, err_step;
	logic [NSLOT-1:0]   slots;

	always_comb begin
		in_field_n = in_field_q;
		in_quote_n = in_quote_q;
		err_n      = err_q;
		cf_n       = cf_q;
		kl_n       = kl_q;
		lkb_n      = lkb_q;
		kl_base    = kl_q;
		do_app     = 1'b0;
		close_q    = 1'b0;
		slots      = '0;
		if (!err_q) begin
			if (in_field_q && in_quote_q) begin
				do_app = 1'b1;
				if (data_byte == QUOTE_BYTE) begin
					in_quote_n = 1'b0;
				end
			end else if (data_byte == delimiter) begin
				if (cf_q >= FIELD_W'(MAXF - 1)) begin
					err_n           = 1'b1;
					in_field_n      = 1'b0;
					in_quote_n      = 1'b0;
					slots[SLOT_MARK] = 1'b1;
				end else begin
					slots[SLOT_CLOSE] = 1'b1;
					close_q           = in_field_q && (lkb_q != QUOTE_BYTE);
					in_field_n        = 1'b0;
					in_quote_n        = 1'b0;
					cf_n              = cf_q + FIELD_W'(1);
				end
			end else if (!in_field_q) begin
				in_field_n = 1'b1;
				kl_base    = '0;
				do_app     = 1'b1;
				if (data_byte == QUOTE_BYTE) begin
					in_quote_n = 1'b1;
				end else begin
					slots[SLOT_OPEN] = 1'b1;
				end
			end else begin
				do_app = 1'b1;
			end
			if (do_app) begin
				kl_n = kl_base;
				if (kl_base < LEN_W'(MAXLEN - 1)) begin
					slots[SLOT_DATA] = 1'b1;
					kl_n             = kl_base + LEN_W'(1);
					lkb_n            = data_byte;
				end
			end
			if (line_last && in_field_n) begin
				slots[SLOT_CLOSE] = 1'b1;
				close_q           = (lkb_n != QUOTE_BYTE);
				in_field_n        = 1'b0;
				in_quote_n        = 1'b0;
			end
		end
		err_step = err_n;
		if (line_last) begin
			if (slots == '0) begin
				slots[SLOT_MARK] = 1'b1;
			end
			in_field_n = 1'b0;
			in_quote_n = 1'b0;
			err_n      = 1'b0;
			cf_n       = '0;
			kl_n       = '0;
			lkb_n      = '0;
		end
	end

	always_comb begin
		push.valid            = accept && (slots != '0);
		push.desc.field_index = IDX_W'(cf_q);
		push.desc.data        = data_byte;
		push.desc.err         = err_step;
		push.desc.line_end    = line_last;
		push.desc.close_quote = close_q;
		push.desc.slots       = slots;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_field_q <= 1'b0;
			in_quote_q <= 1'b0;
			err_q      <= 1'b0;
			cf_q       <= '0;
			kl_q       <= '0;
			lkb_q      <= '0;
		end else if (accept) begin
			in_field_q <= in_field_n;
			in_quote_q <= in_quote_n;
			err_q      <= err_n;
			cf_q       <= cf_n;
			kl_q       <= kl_n;
			lkb_q      <= lkb_n;
		end
	end

endmodule

[hw/rtl/dfs_queue.sv]
// ---------------------------------------------------------------------------
// dfs_queue
// Short descriptor queue between the front and the back.
// ---------------------------------------------------------------------------
module dfs_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  dfs_pkg::push_t push,
	input  logic           pop,
	output logic           full,
	output dfs_pkg::head_t head
);
	import dfs_pkg::*;

	desc_t             entry_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QPTR_W:0]   count_q;
	logic              do_push, do_pop;

	assign full       = (count_q == (QPTR_W + 1)'(QDEPTH));
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && (count_q != '0);
	assign head.valid = (count_q != '0);
	assign head.desc  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + (QPTR_W + 1)'(1);
				2'b01:   count_q <= count_q - (QPTR_W + 1)'(1);
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[hw/rtl/dfs_back.sv]
// ---------------------------------------------------------------------------
// dfs_back
// Expands the head descriptor into result transactions, one per cycle
// while the output is not stalled, into the output register.
// ---------------------------------------------------------------------------
module dfs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dfs_pkg::head_t             head,
	output logic                       pop,
	output logic                       m_tvalid,
	input  logic                       m_tready,
	output logic [15:0]                m_tdata,
	output logic [3:0]                 m_tuser,
	output logic                       m_tlast
);
	import dfs_pkg::*;

	logic [NSLOT-1:0]  done_q, rem, sel;
	logic              load, run_last;
	logic              valid_q;
	logic [IDX_W-1:0]  idx_q;
	logic [BYTE_W-1:0] val_q, val_n;
	logic              bv_q, fe_q, le_q, err_q, last_q;
	logic              bv_n, fe_n;

	assign rem      = head.desc.slots & ~done_q;
	assign sel      = rem & (~rem + NSLOT'(1));
	assign run_last = ((rem & ~sel) == '0);
	assign load     = head.valid && (!valid_q || m_tready);
	assign pop      = load && run_last;

	always_comb begin
		val_n = '0;
		bv_n  = 1'b0;
		fe_n  = 1'b0;
		if (sel[SLOT_OPEN]) begin
			val_n = QUOTE_BYTE;
			bv_n  = 1'b1;
		end else if (sel[SLOT_DATA]) begin
			val_n = head.desc.data;
			bv_n  = 1'b1;
		end else if (sel[SLOT_CLOSE]) begin
			fe_n = 1'b1;
			if (head.desc.close_quote) begin
				val_n = QUOTE_BYTE;
				bv_n  = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			done_q  <= '0;
		end else begin
			if (load) begin
				valid_q <= 1'b1;
				done_q  <= run_last ? '0 : (done_q | sel);
			end else if (m_tready) begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q  <= head.desc.field_index;
			val_q  <= val_n;
			bv_q   <= bv_n;
			fe_q   <= fe_n;
			le_q   <= head.desc.line_end && run_last;
			err_q  <= head.desc.err;
			last_q <= run_last;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata  = {2'b00, val_q, idx_q};
	assign m_tuser  = {err_q, le_q, fe_q, bv_q};
	assign m_tlast  = last_q;

endmodule

[hw/rtl/dfs_checker.sv]
// ---------------------------------------------------------------------------
// dfs_checker
// Port-level checks of the field splitter output stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module dfs_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        m_tvalid,
	input logic        m_tready,
	input logic [15:0] m_tdata,
	input logic [3:0]  m_tuser,
	input logic        m_tlast
);
	import dfs_pkg::*;

	`DFS_ASSERT_NXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tuser))
	`DFS_ASSERT_IMP(a_line_end_last, m_tvalid && m_tuser[2], m_tlast)
	`DFS_ASSERT_IMP(a_no_byte_zero, m_tvalid && !m_tuser[0], m_tdata[13:6] == 8'h00)
	`DFS_ASSERT_IMP(a_close_quote, m_tvalid && m_tuser[1] && m_tuser[0], m_tdata[13:6] == QUOTE_BYTE)

endmodule

bind delimited_field_splitter_unit dfs_checker u_dfs_checker (.*);

[verif/testbench.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for delimited_field_splitter_unit. Line bytes go in on
// the s_* stream, and every transaction on the m_* stream is checked field by
// field against a per-byte model of the splitter. The tests cover quoting,
// empty fields, field truncation, the field-count limit and several delimiter
// values. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module testbench;
	import dfs_pkg::*;

	localparam int PERIOD       = 10;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;
	localparam int RANDOM_ITEMS = 24;

	typedef struct packed {
		logic [IDX_W-1:0]  idx;
		logic [BYTE_W-1:0] val;
		logic              bv;
		logic              fe;
		logic              le;
		logic              ov;
		logic              lr;
	} split_rec_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'h00;
	logic        s_tlast   = 1'b0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [15:0] m_tdata;
	logic [3:0]  m_tuser;
	logic        m_tlast;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [7:0]  cfg_data  = 8'h00;

	// model state
	logic [7:0]  delim_reg = DELIM_RESET;
	logic        in_fld    = 1'b0;
	logic        in_q      = 1'b0;
	logic [15:0] fld_cnt   = '0;
	logic [15:0] keep_len  = '0;
	logic [7:0]  last_kept = 8'h00;
	logic        err_lat   = 1'b0;

	split_rec_t  step_recs[$];
	split_rec_t  split_q[$];

	int tx_gap_pct   = 25;
	int rx_stall_pct = 25;
	int rx_hold      = 0;
	int cycles       = 0;
	int errors       = 0;
	int items_sent   = 0;
	int lines_sent   = 0;
	int results_seen = 0;
	int overflow_cnt = 0;
	int cfg_writes   = 0;

	delimited_field_splitter_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tlast   (s_tlast),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_data  (cfg_data)
	);

	always #(PERIOD / 2) clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t timeout with %0d results outstanding", $time, split_q.size());
			$display("CHECK FAILED");
			$finish;
		end
	end

	function automatic int gap_len(int pct);
		if (pct == 0 || $urandom_range(0, 99) >= pct)
			return 0;
		if ($urandom_range(0, 9) == 0)
			return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	always @(posedge clk) begin
		if (rx_hold > 0) begin
			m_tready <= 1'b0;
			rx_hold  <= rx_hold - 1;
		end else begin
			m_tready <= 1'b1;
			rx_hold  <= gap_len(rx_stall_pct);
		end
	end

	function automatic void push_rec(logic [7:0] b, logic v, logic fe);
		split_rec_t r;
		r.idx = fld_cnt[IDX_W-1:0];
		r.val = b;
		r.bv  = v;
		r.fe  = fe;
		r.le  = 1'b0;
		r.ov  = err_lat;
		r.lr  = 1'b0;
		step_recs.push_back(r);
	endfunction

	function automatic void keep_byte(logic [7:0] d);
		if (keep_len < MAXLEN - 1) begin
			push_rec(d, 1'b1, 1'b0);
			keep_len++;
			last_kept = d;
		end
	endfunction

	function automatic void end_field();
		if (last_kept != QUOTE_BYTE)
			push_rec(QUOTE_BYTE, 1'b1, 1'b1);
		else
			push_rec(8'h00, 1'b0, 1'b1);
		in_fld = 1'b0;
		in_q   = 1'b0;
	endfunction

	function automatic void split_byte(logic [7:0] d, logic last);
		step_recs.delete();
		if (!err_lat) begin
			if (in_fld && in_q) begin
				keep_byte(d);
				if (d == QUOTE_BYTE)
					in_q = 1'b0;
			end else if (d == delim_reg) begin
				if (fld_cnt >= MAXF - 1) begin
					err_lat = 1'b1;
					in_fld  = 1'b0;
					in_q    = 1'b0;
					push_rec(8'h00, 1'b0, 1'b0);
					overflow_cnt++;
				end else if (in_fld) begin
					end_field();
					fld_cnt++;
				end else begin
					push_rec(8'h00, 1'b0, 1'b1);
					fld_cnt++;
				end
			end else if (!in_fld) begin
				in_fld   = 1'b1;
				keep_len = '0;
				if (d == QUOTE_BYTE)
					in_q = 1'b1;
				else
					push_rec(QUOTE_BYTE, 1'b1, 1'b0);
				keep_byte(d);
			end else begin
				keep_byte(d);
			end
			if (last && in_fld)
				end_field();
		end
		if (last) begin
			if (step_recs.size() == 0)
				push_rec(8'h00, 1'b0, 1'b0);
			step_recs[step_recs.size() - 1].le = 1'b1;
			in_fld    = 1'b0;
			in_q      = 1'b0;
			fld_cnt   = '0;
			keep_len  = '0;
			last_kept = 8'h00;
			err_lat   = 1'b0;
		end
		if (step_recs.size() > 0)
			step_recs[step_recs.size() - 1].lr = 1'b1;
		foreach (step_recs[i])
			split_q.push_back(step_recs[i]);
	endfunction

	task automatic report_field(string name, int exp_v, int act_v);
		$display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
		errors++;
	endtask

	always @(posedge clk) begin
		split_rec_t exp_r;
		split_rec_t got_r;
		if (arst_n && m_tvalid && m_tready) begin
			got_r = '{m_tdata[5:0], m_tdata[13:6], m_tuser[0], m_tuser[1], m_tuser[2],
				m_tuser[3], m_tlast};
			results_seen++;
			if (split_q.size() == 0) begin
				$display("%0t unexpected result: expected none, actual %h", $time, got_r);
				errors++;
			end else begin
				exp_r = split_q.pop_front();
				if (got_r.idx !== exp_r.idx)
					report_field("field_index", int'(exp_r.idx), int'(got_r.idx));
				if (got_r.val !== exp_r.val)
					report_field("value_byte", int'(exp_r.val), int'(got_r.val));
				if (got_r.bv !== exp_r.bv)
					report_field("byte_valid", int'(exp_r.bv), int'(got_r.bv));
				if (got_r.fe !== exp_r.fe)
					report_field("field_end", int'(exp_r.fe), int'(got_r.fe));
				if (got_r.le !== exp_r.le)
					report_field("line_end", int'(exp_r.le), int'(got_r.le));
				if (got_r.ov !== exp_r.ov)
					report_field("overflow_error", int'(exp_r.ov), int'(got_r.ov));
				if (got_r.lr !== exp_r.lr)
					report_field("last_of_run", int'(exp_r.lr), int'(got_r.lr));
				if (m_tdata[15:14] !== 2'b00)
					report_field("tdata pad", 0, int'(m_tdata[15:14]));
			end
		end
	end

	task automatic send_byte(logic [7:0] d, logic last);
		int gap;
		gap = gap_len(tx_gap_pct);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= d;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		split_byte(d, last);
		items_sent++;
		if (last)
			lines_sent++;
	endtask

	task automatic wait_drain();
		s_tvalid <= 1'b0;
		while (split_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_delim(logic [7:0] v);
		cfg_valid <= 1'b1;
		cfg_data  <= v;
		do @(posedge clk); while (!cfg_ready);
		delim_reg = v;
		cfg_writes++;
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic send_text(string s, bit last_at_end);
		for (int i = 0; i < s.len(); i++)
			send_byte(s[i], last_at_end && (i == s.len() - 1));
	endtask

	task automatic send_random_line(int len, int delim_pct, int quote_pct);
		int r;
		logic [7:0] d;
		for (int i = 0; i < len; i++) begin
			r = $urandom_range(0, 99);
			if (r < delim_pct)
				d = delim_reg;
			else if (r < delim_pct + quote_pct)
				d = QUOTE_BYTE;
			else
				d = 8'($urandom_range(0, 255));
			send_byte(d, i == len - 1);
		end
	endtask

	task automatic test_directed();
		send_text("ab,\"c,d\"e,,\"q\"", 1'b1);
		send_byte(8'h00, 1'b0);
		send_byte(8'hFF, 1'b0);
		send_text(",", 1'b1);
		send_text("\"open", 1'b1);
		send_text(",", 1'b1);
		send_text("x", 1'b1);
		send_text("\"", 1'b1);
		wait_drain();
	endtask

	// fill the field count, run a quoted field past the length cap, then overflow
	task automatic test_limits();
		for (int i = 0; i < MAXF - 1; i++)
			send_byte(delim_reg, 1'b0);
		send_byte(QUOTE_BYTE, 1'b0);
		for (int i = 0; i < MAXLEN + 1; i++)
			send_byte((i % 9 == 4) ? delim_reg : 8'($urandom_range(97, 122)), 1'b0);
		send_byte(QUOTE_BYTE, 1'b0);
		send_byte(delim_reg, 1'b0);
		send_text("z", 1'b1);
		wait_drain();
	endtask

	task automatic test_delimiters();
		logic [7:0] vals[4];
		vals = '{8'd0, 8'd255, QUOTE_BYTE, 8'($urandom_range(0, 255))};
		foreach (vals[k]) begin
			write_delim(vals[k]);
			send_random_line($urandom_range(3, 6), 30, 10);
			if (vals[k] == QUOTE_BYTE)
				send_text("a\"\"b\"", 1'b1);
			wait_drain();
		end
		write_delim(DELIM_RESET);
	endtask

	task automatic random_phase(int target);
		int stop_at;
		int kind;
		stop_at = items_sent + target;
		while (items_sent < stop_at) begin
			kind = $urandom_range(0, 4);
			if (kind == 0)
				send_random_line($urandom_range(1, 10), 0, 0);
			else
				send_random_line($urandom_range(1, 10), 25, 10);
		end
		wait_drain();
	endtask

	task automatic test_random();
		random_phase(RANDOM_ITEMS / 3);
		write_delim(8'($urandom_range(0, 255)));
		tx_gap_pct   = 0;
		rx_stall_pct = 0;
		random_phase(RANDOM_ITEMS / 3);
		tx_gap_pct   = 40;
		rx_stall_pct = 40;
		write_delim(DELIM_RESET);
		random_phase(RANDOM_ITEMS / 3);
	endtask

	initial begin
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_limits();
		test_delimiters();
		test_random();
		wait_drain();
		$display("Sent %0d bytes in %0d lines, checked %0d results", items_sent, lines_sent,
			results_seen);
		$display("Saw %0d field-limit overflows across %0d delimiter writes", overflow_cnt,
			cfg_writes);
		if (errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
